/* rtl/core/lgrs_pkg.sv */
// Package: shared types and constants for the Life generation row stream.
`default_nettype none

package lgrs_pkg;

    localparam int ROW_W = 64;

    // Rule B3/S23 neighbor counts
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef enum logic [1:0] {
        FILL_EMPTY,
        FILL_ONE,
        FILL_FULL
    } t_fill;

    typedef struct packed {
        logic [ROW_W-1:0] next_cells;
        logic             grid_done;
    } t_out_item;

    // Up to two results per accepted row; push1 only ever with push0.
    typedef struct packed {
        logic      push0;
        logic      push1;
        t_out_item item0;
        t_out_item item1;
    } t_push;

endpackage

`default_nettype wire

/* rtl/core/lgrs_ifs.sv */
// Interfaces: row input channel and next-generation output channel.
`default_nettype none

interface lgrs_row_if import lgrs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_cells;
    logic             final_row;

    modport source (output valid, output row_cells, output final_row, input ready);
    modport sink   (input valid, input row_cells, input final_row, output ready);
endinterface

interface lgrs_next_if import lgrs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] next_cells;
    logic             grid_done;

    modport source (output valid, output next_cells, output grid_done, input ready);
    modport sink   (input valid, input next_cells, input grid_done, output ready);
endinterface

`default_nettype wire

/* rtl/core/lgrs_lane.sv */
// Lane: B3/S23 rule for one cell from its 3x3 neighborhood.
`default_nettype none

module lgrs_lane import lgrs_pkg::*; (
    input  logic [2:0] i_above,
    input  logic [2:0] i_mid,
    input  logic [2:0] i_below,
    output logic       o_alive
);

    logic [3:0] nbr_cnt;

    assign nbr_cnt = 4'(i_above[0]) + 4'(i_above[1]) + 4'(i_above[2])
                   + 4'(i_mid[0])   + 4'(i_mid[2])
                   + 4'(i_below[0]) + 4'(i_below[1]) + 4'(i_below[2]);

    assign o_alive = (nbr_cnt == BIRTH_COUNT) || (i_mid[1] && (nbr_cnt == SURVIVE_COUNT));

endmodule

`default_nettype wire

/* rtl/core/lgrs_merge.sv */
// Merge: assembles the lane results into a row, border columns pass through.
`default_nettype none

module lgrs_merge import lgrs_pkg::*; #(
    parameter int GRID_SIZE = 64
) (
    input  logic [ROW_W-1:0] i_lane,
    input  logic [ROW_W-1:0] i_mid,
    input  logic             i_top_pass,
    output logic [ROW_W-1:0] o_row
);

    logic [ROW_W-1:0] stencil_row;

    // i_mid is already masked to the grid width
    always_comb begin
        for (int j = 0; j < ROW_W; j++) begin
            if (j >= 1 && j <= GRID_SIZE - 2) begin
                stencil_row[j] = i_lane[j];
            end else begin
                stencil_row[j] = i_mid[j];
            end
        end
    end

    // top row goes out unchanged
    assign o_row = i_top_pass ? i_mid : stencil_row;

endmodule

`default_nettype wire

/* rtl/core/lgrs_outq.sv */
// Output queue: three-entry FIFO taking up to two items per cycle.
`default_nettype none

module lgrs_outq import lgrs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_push       i_push,
    output logic        o_room,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item
);

    localparam int DEPTH = 3;

    t_out_item  r_q [DEPTH];
    logic [1:0] r_rd, n_rd;
    logic [1:0] r_wr, n_wr;
    logic [1:0] r_cnt, n_cnt;
    logic [1:0] wr_next;
    logic       pop;

    function automatic logic [1:0] inc3(input logic [1:0] p);
        return (p == 2'(DEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

    assign o_valid = (r_cnt != 2'd0);
    assign o_room  = (r_cnt <= 2'd1);
    assign o_item  = r_q[r_rd];
    assign pop     = o_valid && i_ready;
    assign wr_next = inc3(r_wr);

    always_comb begin
        n_rd  = pop ? inc3(r_rd) : r_rd;
        n_wr  = r_wr;
        n_cnt = r_cnt - 2'(pop);
        if (i_push.push0 && i_push.push1) begin
            n_wr  = inc3(wr_next);
            n_cnt = n_cnt + 2'd2;
        end else if (i_push.push0) begin
            n_wr  = wr_next;
            n_cnt = n_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 2'd0;
            r_wr  <= 2'd0;
            r_cnt <= 2'd0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_q[r_wr] <= i_push.item0;
        end
        if (i_push.push1) begin
            r_q[wr_next] <= i_push.item1;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/life_generation_row_stream.sv */
// Top level: row-streamed Conway Life generation step (B3/S23).
//
//  channel  | dir | payload                      | accepted when
//  ---------+-----+------------------------------+-------------------
//  i_row    | in  | row_cells[63:0], final_row   | valid && ready
//  o_next   | out | next_cells[63:0], grid_done  | valid && ready
//
// One row per clock sustained while i_row.ready is high: all cells of a row
// are evaluated by parallel lanes in the accept cycle and written to a
// three-entry output FIFO. A final row queues two items, or one if it is
// the first row of a grid. i_row.ready drops only while two or more items
// wait. Synchronous active-low reset empties line buffers and the FIFO.
`default_nettype none

module life_generation_row_stream import lgrs_pkg::*; #(
    parameter int GRID_SIZE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lgrs_row_if.sink    i_row,
    lgrs_next_if.source o_next
);

    localparam logic [ROW_W-1:0] COL_MASK =
        (GRID_SIZE >= ROW_W) ? {ROW_W{1'b1}} : ((ROW_W'(1) << GRID_SIZE) - ROW_W'(1));

    logic [ROW_W-1:0] r_older, n_older;
    logic [ROW_W-1:0] r_newer, n_newer;
    t_fill            r_fill, n_fill;

    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] lane_vec;
    logic [ROW_W-1:0] merged_row;
    logic             accept;
    logic             room;
    t_push            push;
    t_out_item        q_item;

    assign row    = i_row.row_cells & COL_MASK;
    assign accept = i_row.valid && room;
    assign i_row.ready = room;

    // Lanes: one per inner column, the rest unused
    genvar j;
    generate
        for (j = 0; j < ROW_W; j++) begin : g_lane
            if (j >= 1 && j <= GRID_SIZE - 2) begin : g_inner
                lgrs_lane u_lane (
                    .i_above (r_older[j+1:j-1]),
                    .i_mid   (r_newer[j+1:j-1]),
                    .i_below (row[j+1:j-1]),
                    .o_alive (lane_vec[j])
                );
            end else begin : g_edge
                assign lane_vec[j] = 1'b0;
            end
        end
    endgenerate

    lgrs_merge #(
        .GRID_SIZE (GRID_SIZE)
    ) u_merge (
        .i_lane     (lane_vec),
        .i_mid      (r_newer),
        .i_top_pass (r_fill == FILL_ONE),
        .o_row      (merged_row)
    );

    // Next state of line buffers and fill level
    always_comb begin
        n_older = r_older;
        n_newer = r_newer;
        n_fill  = r_fill;
        if (accept) begin
            if (i_row.final_row) begin
                n_older = '0;
                n_newer = '0;
                n_fill  = FILL_EMPTY;
            end else begin
                n_older = r_newer;
                n_newer = row;
                n_fill  = (r_fill == FILL_EMPTY) ? FILL_ONE : FILL_FULL;
            end
        end
    end

    // Results released by the accepted row
    always_comb begin
        push.push0 = 1'b0;
        push.push1 = 1'b0;
        push.item0 = '{next_cells: merged_row, grid_done: 1'b0};
        push.item1 = '{next_cells: row, grid_done: 1'b1};
        if (accept) begin
            unique case (r_fill)
                FILL_EMPTY: begin
                    if (i_row.final_row) begin
                        push.push0 = 1'b1;
                        push.item0 = '{next_cells: row, grid_done: 1'b1};
                    end
                end
                FILL_ONE, FILL_FULL: begin
                    push.push0 = 1'b1;
                    push.push1 = i_row.final_row;
                end
                default: begin
                    push.push0 = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older <= '0;
            r_newer <= '0;
            r_fill  <= FILL_EMPTY;
        end else begin
            r_older <= n_older;
            r_newer <= n_newer;
            r_fill  <= n_fill;
        end
    end

    lgrs_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_next.valid),
        .i_ready (o_next.ready),
        .o_item  (q_item)
    );

    assign o_next.next_cells = q_item.next_cells;
    assign o_next.grid_done  = q_item.grid_done;

endmodule

`default_nettype wire

/* rtl/core/lgrs_checker.sv */
// Checker: port-level properties of the Life row stream, bound to the top.
`default_nettype none

module lgrs_checker import lgrs_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [ROW_W-1:0] i_out_cells,
    input logic             i_out_done
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_cells)
                                        && $stable(i_out_done))
        else $error("stalled output item changed");

    // input backpressure only while results wait
    a_stall_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no pending output");

    // backpressure cannot clear without an output taken
    a_stall_persists: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready && !(i_out_valid && i_out_ready) |=> !i_in_ready)
        else $error("input stall released without draining");

    // nothing queued right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind life_generation_row_stream lgrs_checker u_lgrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_row.ready),
    .i_out_valid (o_next.valid),
    .i_out_ready (o_next.ready),
    .i_out_cells (o_next.next_cells),
    .i_out_done  (o_next.grid_done)
);

`default_nettype wire

/* bench/testbench.sv */
// Testbench: streams Life grids row by row, predicts each next-generation row, checks it.
`timescale 1ns / 100ps

module testbench import lgrs_pkg::*; ();

    localparam int GRID = 64;
    localparam logic [ROW_W-1:0] COL_MASK = {ROW_W{1'b1}} >> (ROW_W - GRID);
    localparam int STALL_LIMIT = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lgrs_row_if  row_ch ();
    lgrs_next_if next_ch ();

    life_generation_row_stream #(.GRID_SIZE(GRID)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_row   (row_ch),
        .o_next  (next_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state: the two buffered rows and a count of grid rows taken so far (saturates at 127)
    logic [ROW_W-1:0] line_older;
    logic [ROW_W-1:0] line_newer;
    logic [6:0]       rows_buffered;
    t_out_item        pending_rows[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_left = 0;
    int rows_sent = 0;
    int grids_sent = 0;
    int results_checked = 0;
    int fail_count = 0;
    int quiet_cycles = 0;

    function automatic logic [ROW_W-1:0] next_generation(
        input logic [ROW_W-1:0] above,
        input logic [ROW_W-1:0] mid,
        input logic [ROW_W-1:0] below
    );
        logic [ROW_W-1:0] res;
        logic [3:0]       n;
        res = mid;
        // border columns keep their value
        for (int j = 1; j < GRID - 1; j++) begin
            n = 4'd0;
            for (int k = j - 1; k <= j + 1; k++) begin
                n = n + above[k] + below[k];
                if (k != j)
                    n = n + mid[k];
            end
            res[j] = (n == BIRTH_COUNT) || (mid[j] && n == SURVIVE_COUNT);
        end
        return res & COL_MASK;
    endfunction

    task automatic clear_lines();
        line_older    = '0;
        line_newer    = '0;
        rows_buffered = '0;
    endtask

    task automatic predict_row(input logic [ROW_W-1:0] cells, input logic fin);
        logic [ROW_W-1:0] row;
        row = cells & COL_MASK;
        if (rows_buffered == 0) begin
            if (fin) begin
                pending_rows.push_back('{next_cells: row, grid_done: 1'b1});
            end else begin
                line_newer    = row;
                rows_buffered = 7'd1;
            end
        end else begin
            // row right after the top releases the top row as border
            if (rows_buffered == 7'd1)
                pending_rows.push_back('{next_cells: line_newer, grid_done: 1'b0});
            else
                pending_rows.push_back('{next_cells: next_generation(line_older, line_newer, row),
                                         grid_done: 1'b0});
            if (fin) begin
                pending_rows.push_back('{next_cells: row, grid_done: 1'b1});
                clear_lines();
            end else begin
                line_older = line_newer;
                line_newer = row;
                if (rows_buffered < 7'd127)
                    rows_buffered = rows_buffered + 7'd1;
            end
        end
    endtask

    task automatic send_row(input logic [ROW_W-1:0] cells, input logic fin);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            row_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        row_ch.valid     <= 1'b1;
        row_ch.row_cells <= cells;
        row_ch.final_row <= fin;
        @(posedge i_clk);
        while (!row_ch.ready)
            @(posedge i_clk);
        predict_row(cells, fin);
        rows_sent++;
        if (fin)
            grids_sent++;
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        row_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_rows.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [ROW_W-1:0] random_row();
        logic [ROW_W-1:0] a;
        logic [ROW_W-1:0] b;
        int               mode;
        a    = {$urandom, $urandom};
        b    = {$urandom, $urandom};
        mode = $urandom_range(9);
        case (mode)
            5, 6:    return a & b;
            7:       return a | b;
            8:       return a & b & {$urandom, $urandom};
            9:       return $urandom_range(1) ? '1 : '0;
            default: return a;
        endcase
    endfunction

    task automatic send_grid(input int height);
        for (int r = 0; r < height; r++)
            send_row(random_row(), r == height - 1);
    endtask

    // receiver: random stalls, or a long hold-off counted down here
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            next_ch.ready <= 1'b0;
            rx_hold_left  <= rx_hold_left - 1;
        end else begin
            next_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && next_ch.valid && next_ch.ready) begin
            if (pending_rows.size() == 0) begin
                $error("unexpected result: next_cells %h grid_done %b",
                       next_ch.next_cells, next_ch.grid_done);
                fail_count++;
            end else begin
                want = pending_rows.pop_front();
                results_checked++;
                if (next_ch.next_cells !== want.next_cells) begin
                    $error("next_cells mismatch: expected %h, got %h",
                           want.next_cells, next_ch.next_cells);
                    fail_count++;
                end
                if (next_ch.grid_done !== want.grid_done) begin
                    $error("grid_done mismatch: expected %b, got %b",
                           want.grid_done, next_ch.grid_done);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (row_ch.valid && row_ch.ready) || (next_ch.valid && next_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // final row arriving as the first row of a grid
    task automatic test_lone_final_row();
        send_row('1, 1'b1);
        send_row('0, 1'b1);
        end_burst();
    endtask

    task automatic test_two_row_grid();
        send_row('1, 1'b0);
        send_row(64'h8000_0000_0000_0001, 1'b1);
        end_burst();
    endtask

    task automatic test_patterns();
        // vertical blinker turns horizontal
        send_row('0, 1'b0);
        send_row(64'h4, 1'b0);
        send_row(64'h4, 1'b0);
        send_row(64'h4, 1'b0);
        send_row('0, 1'b1);
        // fully alive: overcrowding inside, border kept
        for (int r = 0; r < 4; r++)
            send_row('1, r == 3);
        for (int r = 0; r < 4; r++)
            send_row(r[0] ? 64'hAAAA_AAAA_AAAA_AAAA : 64'h5555_5555_5555_5555, r == 3);
        end_burst();
    endtask

    // receiver holds off while rows keep coming, then sender waits for all results
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_hold_left = 200;
        send_grid(40);
        end_burst();
        drain();
    endtask

    task automatic test_tall_grid();
        send_grid(130);
        end_burst();
    endtask

    task automatic test_random_grids(input int tx_pct, input int rx_pct, input int row_goal);
        int stop_at;
        int pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at     = rows_sent + row_goal;
        while (rows_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_grid($urandom_range(1, 2));
            else if (pick < 82)
                send_grid($urandom_range(3, 12));
            else if (pick < 97)
                send_grid($urandom_range(13, GRID - 1));
            else
                send_grid(GRID);
            if ($urandom_range(9) == 0)
                end_burst();
        end
        end_burst();
        drain();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        row_ch.valid     = 1'b0;
        row_ch.row_cells = '0;
        row_ch.final_row = 1'b0;
        next_ch.ready    = 1'b0;
        clear_lines();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 21;
        rx_idle_pct = 63;
        test_lone_final_row();
        test_two_row_grid();
        test_patterns();
        drain();
        test_backpressure();

        test_random_grids(21, 63, 440);
        test_random_grids(63, 21, 440);
        test_tall_grid();
        test_random_grids(0, 0, 320);

        drain();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d grids, %0d rows in, %0d result rows checked.",
                 grids_sent, rows_sent, results_checked);
        $display("Grids of 1 to 130 rows, a long output stall, three idle mixes.");
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
